// File: design/gtp_pkg.sv
// ============================================================================
// gtp_pkg: shared types and constants of the Gaussian taper pixel block
// Register codes, fixed-point formats, range reduction constants and the
// reciprocal table of the series divider.
// ============================================================================
`default_nettype none

package gtp_pkg;

  // Configuration register formats
  localparam int unsigned DIM_BITS     = 13;
  localparam int unsigned CTR_BITS     = DIM_BITS - 1;
  localparam int unsigned DIM_RESET    = 256;
  localparam int unsigned COEF_BITS    = 40;
  localparam int unsigned COEF_HALF    = COEF_BITS / 2;
  localparam int unsigned CFG_IDX_BITS = 3;

  // Coefficient fraction bits: the exponent sum is in units of 2^-COEF_FRAC_BITS
  localparam int unsigned COEF_FRAC_BITS = 36;

  // Exponent in Q.32; an exponent of 32.0 or more underflows
  localparam int unsigned Q_FRAC       = 32;
  localparam int unsigned UNF_INT_BITS = 5;
  localparam int unsigned X_BITS       = UNF_INT_BITS + Q_FRAC;

  // ln 2 in Q.32
  localparam logic [Q_FRAC-1:0] LN2_Q32 = 32'd2977044472;

  // Quotient estimate: n_est = ((x >> XH_SHIFT) * RECIP_LN2) >> RECIP_SHIFT
  localparam int unsigned XH_SHIFT    = 24;
  localparam int unsigned XH_BITS     = X_BITS - XH_SHIFT;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_BITS  = 9;
  localparam logic [RECIP_BITS-1:0] RECIP_LN2 =
    RECIP_BITS'((64'd1 << (XH_SHIFT + RECIP_SHIFT)) / 64'(LN2_Q32));

  // Power of two count after range reduction
  localparam int unsigned N_BITS = 6;
  localparam logic [N_BITS-1:0] N_MAX = N_BITS'((64'd1 << X_BITS) / 64'(LN2_Q32));

  // Series accumulator holds up to exactly 1.0 in Q.32
  localparam int unsigned TSUM_BITS    = Q_FRAC + 1;
  localparam int unsigned TAYLOR_TERMS = 13;

  // Division by a term number k: floor(p / k) = (p * ceil(2^36 / k)) >> 36
  // exactly for any 32-bit p and k up to 16.
  localparam int unsigned DIV_SHIFT  = 36;
  localparam int unsigned MAGIC_BITS = 36;
  localparam logic [63:0] DIV_ONE    = 64'd1 << DIV_SHIFT;

  typedef logic [MAGIC_BITS-1:0] magic_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_UU      = 3'd2,
    REG_COEF_UV      = 3'd3,
    REG_COEF_VV      = 3'd4
  } cfg_reg_e;

  // Reciprocal of the term number, rounded up
  function automatic magic_t div_magic(input logic [3:0] k);
    magic_t m;
    case (k)
      4'd2:    m = MAGIC_BITS'((DIV_ONE + 64'd1) / 64'd2);
      4'd3:    m = MAGIC_BITS'((DIV_ONE + 64'd2) / 64'd3);
      4'd4:    m = MAGIC_BITS'((DIV_ONE + 64'd3) / 64'd4);
      4'd5:    m = MAGIC_BITS'((DIV_ONE + 64'd4) / 64'd5);
      4'd6:    m = MAGIC_BITS'((DIV_ONE + 64'd5) / 64'd6);
      4'd7:    m = MAGIC_BITS'((DIV_ONE + 64'd6) / 64'd7);
      4'd8:    m = MAGIC_BITS'((DIV_ONE + 64'd7) / 64'd8);
      4'd9:    m = MAGIC_BITS'((DIV_ONE + 64'd8) / 64'd9);
      4'd10:   m = MAGIC_BITS'((DIV_ONE + 64'd9) / 64'd10);
      4'd11:   m = MAGIC_BITS'((DIV_ONE + 64'd10) / 64'd11);
      4'd12:   m = MAGIC_BITS'((DIV_ONE + 64'd11) / 64'd12);
      4'd13:   m = MAGIC_BITS'((DIV_ONE + 64'd12) / 64'd13);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: design/gaussian_taper_pixel_top.sv
// ============================================================================
// gaussian_taper_pixel_top: elliptical Gaussian taper, one pixel per clock
// Forms u, v from the pixel index and the image centre, the exponent
// a*u*u + b*u*v + c*v*v in fixed point, and exp(-exponent) in Q1.AMP_FRAC_BITS.
// ============================================================================
`default_nettype none

// The block takes one pixel word per clock while in_stall_o is low and returns
// one amplitude word per pixel, in order. Every multiplier has a register
// stage of its own; the depth of the pipeline is set by the exponential series,
// whose twelve product/divide steps take two stages each. A stalled output
// word is backed by a one-word skid register; once that is full the input is
// stalled and the whole pipeline holds. Configuration must be written through
// the plain write port while no pixels are in flight (the block does not
// enforce this); the center registers keep half the written width and height.
module gaussian_taper_pixel_top #(
  parameter int unsigned INDEX_BITS    = 12,
  parameter int unsigned AMP_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [gtp_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [gtp_pkg::COEF_BITS-1:0]      cfg_data_i,
  // pixel input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [INDEX_BITS-1:0]              col_index_i,
  input  logic [INDEX_BITS-1:0]              row_index_i,
  // amplitude output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [AMP_FRAC_BITS:0]             amplitude_o
);
  import gtp_pkg::*;

  localparam int unsigned MAG_BITS  = (INDEX_BITS > CTR_BITS) ? INDEX_BITS : CTR_BITS;
  localparam int unsigned SQ_BITS   = 2 * MAG_BITS;
  localparam int unsigned PP_BITS   = SQ_BITS + COEF_HALF;
  localparam int unsigned PROD_BITS = SQ_BITS + COEF_BITS;
  localparam int unsigned PSUM_BITS = PROD_BITS + 1;
  localparam int unsigned EXP_BITS  = PROD_BITS + 2;
  localparam int unsigned NP_BITS   = XH_BITS + RECIP_BITS;
  localparam int unsigned TP_BITS   = 2 * Q_FRAC;
  localparam int unsigned DP_BITS   = Q_FRAC + MAGIC_BITS;
  localparam int unsigned TSTEPS    = TAYLOR_TERMS - 1;
  localparam int unsigned AMP_BITS  = AMP_FRAC_BITS + 1;
  localparam int unsigned SH_BITS   = 8;
  localparam int unsigned SH_LIMIT  = 63;
  localparam int unsigned RND_BITS  = 64;
  localparam int unsigned RSH_BITS  = 6;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CTR_BITS-1:0]  col_ctr_q, row_ctr_q;
  logic [COEF_BITS-1:0] coef_uu_q, coef_vv_q, uv_mag_q;
  logic                 uv_neg_q;
  logic [COEF_BITS-1:0] uv_mag_d;

  // u*v coefficient kept as sign and magnitude
  assign uv_mag_d = cfg_data_i[COEF_BITS-1] ? (COEF_BITS'(0) - cfg_data_i) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_ctr_q <= CTR_BITS'(DIM_RESET / 2);
      row_ctr_q <= CTR_BITS'(DIM_RESET / 2);
      coef_uu_q <= '0;
      coef_vv_q <= '0;
      uv_mag_q  <= '0;
      uv_neg_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  col_ctr_q <= cfg_data_i[DIM_BITS-1:1];
        REG_IMAGE_HEIGHT: row_ctr_q <= cfg_data_i[DIM_BITS-1:1];
        REG_COEF_UU:      coef_uu_q <= cfg_data_i;
        REG_COEF_UV: begin
          uv_mag_q <= uv_mag_d;
          uv_neg_q <= cfg_data_i[COEF_BITS-1];
        end
        REG_COEF_VV:      coef_vv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: the pipeline moves unless the skid register is full
  // --------------------------------------------------------------------------
  logic adv;
  logic skid_vld_q, out_vld_q;
  logic [AMP_BITS-1:0] skid_amp_q, out_amp_q;

  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // --------------------------------------------------------------------------
  // Stage 1: offsets from the center, as magnitude and sign
  // --------------------------------------------------------------------------
  logic [MAG_BITS-1:0] col_m, row_m, cctr_m, rctr_m;
  logic                col_lt, row_lt;
  logic [MAG_BITS-1:0] s1_umag_d, s1_vmag_d;
  logic                s1_vld_q, s1_neg_q;
  logic [MAG_BITS-1:0] s1_umag_q, s1_vmag_q;

  always_comb begin
    col_m     = MAG_BITS'(col_index_i);
    row_m     = MAG_BITS'(row_index_i);
    cctr_m    = MAG_BITS'(col_ctr_q);
    rctr_m    = MAG_BITS'(row_ctr_q);
    col_lt    = col_m < cctr_m;
    row_lt    = row_m < rctr_m;
    s1_umag_d = col_lt ? (cctr_m - col_m) : (col_m - cctr_m);
    s1_vmag_d = row_lt ? (rctr_m - row_m) : (row_m - rctr_m);
  end

  // --------------------------------------------------------------------------
  // Stages 2 to 6: squares, partial products, products, exponent sum
  // --------------------------------------------------------------------------
  logic                 s2_vld_q, s2_sub_q;
  logic [SQ_BITS-1:0]   s2_uu_q, s2_vv_q, s2_uv_q;
  logic                 s3_vld_q, s3_sub_q;
  logic [PP_BITS-1:0]   s3_uu_lo_q, s3_uu_hi_q, s3_vv_lo_q, s3_vv_hi_q;
  logic [PP_BITS-1:0]   s3_uv_lo_q, s3_uv_hi_q;
  logic                 s4_vld_q, s4_sub_q;
  logic [PROD_BITS-1:0] s4_uu_q, s4_vv_q, s4_uv_q;
  logic                 s5_vld_q, s5_sub_q;
  logic [PSUM_BITS-1:0] s5_p_q;
  logic [PROD_BITS-1:0] s5_m_q;
  logic                 s6_vld_q;
  logic [EXP_BITS-1:0]  s6_e_q, s6_e_d;
  logic                 p_lt_m;

  // cross term subtracts when its sign disagrees with the coefficient sign
  always_comb begin
    p_lt_m = s5_p_q < PSUM_BITS'(s5_m_q);
    if (s5_sub_q) begin
      s6_e_d = p_lt_m ? '0 : EXP_BITS'(s5_p_q - PSUM_BITS'(s5_m_q));
    end else begin
      s6_e_d = EXP_BITS'(s5_p_q) + EXP_BITS'(s5_m_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 7 to 9: Q.32 exponent, underflow, range reduction by ln 2
  // --------------------------------------------------------------------------
  logic                s7_vld_q, s7_unf_q, s7_unf_d;
  logic [X_BITS-1:0]   s7_x_q, s7_x_d;
  logic [NP_BITS-1:0]  nest_prod;
  logic                s8_vld_q, s8_unf_q;
  logic [X_BITS-1:0]   s8_x_q;
  logic [N_BITS-1:0]   s8_nest_q, s8_nest_d;
  logic [X_BITS-1:0]   nl_prod;
  logic                s9_vld_q, s9_unf_q;
  logic [TSUM_BITS-1:0] s9_r0_q, s9_r0_d;
  logic [N_BITS-1:0]   s9_n_q;
  logic                r_ge;

  always_comb begin
    s7_unf_d = |s6_e_q[EXP_BITS-1:COEF_FRAC_BITS+UNF_INT_BITS];
    s7_x_d   = X_BITS'({s6_e_q[COEF_FRAC_BITS+UNF_INT_BITS-1:0], {Q_FRAC{1'b0}}}
                       >> COEF_FRAC_BITS);
    // quotient estimate is n or n-1
    nest_prod = NP_BITS'(s7_x_q[X_BITS-1:XH_SHIFT]) * NP_BITS'(RECIP_LN2);
    s8_nest_d = N_BITS'(nest_prod >> RECIP_SHIFT);
    nl_prod   = X_BITS'(s8_nest_q) * X_BITS'(LN2_Q32);
    s9_r0_d   = TSUM_BITS'(s8_x_q - nl_prod);
    r_ge      = s9_r0_q >= TSUM_BITS'(LN2_Q32);
  end

  // --------------------------------------------------------------------------
  // Series for exp(-r): index 0 holds the corrected remainder (term 1 = r)
  // and the sum 1.0; step j forms term j+1 in an A stage (product) and a
  // B stage (divide), and the A stage folds the previous term into the sum.
  // --------------------------------------------------------------------------
  logic [Q_FRAC-1:0]    b_term_q [0:TSTEPS];
  logic [Q_FRAC-1:0]    b_r_q    [0:TSTEPS];
  logic [TSUM_BITS-1:0] b_sum_q  [0:TSTEPS];
  logic [N_BITS-1:0]    b_n_q    [0:TSTEPS];
  logic                 b_unf_q  [0:TSTEPS];
  logic                 b_vld_q  [0:TSTEPS];
  logic [Q_FRAC-1:0]    b_term_d [1:TSTEPS];

  logic [Q_FRAC-1:0]    a_p_q   [1:TSTEPS];
  logic [Q_FRAC-1:0]    a_r_q   [1:TSTEPS];
  logic [TSUM_BITS-1:0] a_sum_q [1:TSTEPS];
  logic [N_BITS-1:0]    a_n_q   [1:TSTEPS];
  logic                 a_unf_q [1:TSTEPS];
  logic                 a_vld_q [1:TSTEPS];
  logic [Q_FRAC-1:0]    a_p_d   [1:TSTEPS];
  logic [TSUM_BITS-1:0] a_sum_d [1:TSTEPS];

  logic [Q_FRAC-1:0]    b0_r_d;
  logic [N_BITS-1:0]    b0_n_d;

  always_comb begin
    b0_r_d = Q_FRAC'(r_ge ? (s9_r0_q - TSUM_BITS'(LN2_Q32)) : s9_r0_q);
    b0_n_d = r_ge ? (s9_n_q + N_BITS'(1)) : s9_n_q;
    for (int j = 1; j <= TSTEPS; j++) begin
      a_p_d[j] = Q_FRAC'((TP_BITS'(b_term_q[j-1]) * TP_BITS'(b_r_q[j-1])) >> Q_FRAC);
      // odd terms subtract, even terms add
      if ((j & 1) != 0) begin
        a_sum_d[j] = b_sum_q[j-1] - TSUM_BITS'(b_term_q[j-1]);
      end else begin
        a_sum_d[j] = b_sum_q[j-1] + TSUM_BITS'(b_term_q[j-1]);
      end
      b_term_d[j] = Q_FRAC'((DP_BITS'(a_p_q[j]) * DP_BITS'(div_magic(4'(j + 1))))
                            >> DIV_SHIFT);
    end
  end

  // --------------------------------------------------------------------------
  // Final stage: last term, then scale by 2^-n with rounding
  // --------------------------------------------------------------------------
  logic                 f_vld_q, f_unf_q;
  logic [TSUM_BITS-1:0] f_sum_q, f_sum_d;
  logic [N_BITS-1:0]    f_n_q;
  logic [SH_BITS-1:0]   sh;
  logic [RND_BITS-1:0]  rnd_val;
  logic [AMP_BITS-1:0]  amp_d;

  always_comb begin
    if (((TSTEPS + 1) & 1) != 0) begin
      f_sum_d = b_sum_q[TSTEPS] - TSUM_BITS'(b_term_q[TSTEPS]);
    end else begin
      f_sum_d = b_sum_q[TSTEPS] + TSUM_BITS'(b_term_q[TSTEPS]);
    end
    sh      = SH_BITS'(Q_FRAC) + SH_BITS'(f_n_q) - SH_BITS'(AMP_FRAC_BITS);
    rnd_val = (RND_BITS'(f_sum_q) + (RND_BITS'(1) << RSH_BITS'(sh - SH_BITS'(1))))
              >> RSH_BITS'(sh);
    if (f_unf_q || (sh >= SH_BITS'(SH_LIMIT))) begin
      amp_d = '0;
    end else begin
      amp_d = AMP_BITS'(rnd_val);
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits travel with the data
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      s9_vld_q <= 1'b0;
      f_vld_q  <= 1'b0;
      for (int j = 0; j <= TSTEPS; j++) begin
        b_vld_q[j] <= 1'b0;
      end
      for (int j = 1; j <= TSTEPS; j++) begin
        a_vld_q[j] <= 1'b0;
      end
    end else if (adv) begin
      s1_vld_q   <= in_valid_i;
      s2_vld_q   <= s1_vld_q;
      s3_vld_q   <= s2_vld_q;
      s4_vld_q   <= s3_vld_q;
      s5_vld_q   <= s4_vld_q;
      s6_vld_q   <= s5_vld_q;
      s7_vld_q   <= s6_vld_q;
      s8_vld_q   <= s7_vld_q;
      s9_vld_q   <= s8_vld_q;
      b_vld_q[0] <= s9_vld_q;
      for (int j = 1; j <= TSTEPS; j++) begin
        a_vld_q[j] <= b_vld_q[j-1];
        b_vld_q[j] <= a_vld_q[j];
      end
      f_vld_q    <= b_vld_q[TSTEPS];
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline data registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      s1_umag_q <= s1_umag_d;
      s1_vmag_q <= s1_vmag_d;
      s1_neg_q  <= col_lt ^ row_lt;
      // stage 2: squares and cross product of the offsets
      s2_uu_q  <= SQ_BITS'(s1_umag_q) * SQ_BITS'(s1_umag_q);
      s2_vv_q  <= SQ_BITS'(s1_vmag_q) * SQ_BITS'(s1_vmag_q);
      s2_uv_q  <= SQ_BITS'(s1_umag_q) * SQ_BITS'(s1_vmag_q);
      s2_sub_q <= s1_neg_q ^ uv_neg_q;
      // stage 3: coefficient halves
      s3_uu_lo_q <= PP_BITS'(s2_uu_q) * PP_BITS'(coef_uu_q[COEF_HALF-1:0]);
      s3_uu_hi_q <= PP_BITS'(s2_uu_q) * PP_BITS'(coef_uu_q[COEF_BITS-1:COEF_HALF]);
      s3_vv_lo_q <= PP_BITS'(s2_vv_q) * PP_BITS'(coef_vv_q[COEF_HALF-1:0]);
      s3_vv_hi_q <= PP_BITS'(s2_vv_q) * PP_BITS'(coef_vv_q[COEF_BITS-1:COEF_HALF]);
      s3_uv_lo_q <= PP_BITS'(s2_uv_q) * PP_BITS'(uv_mag_q[COEF_HALF-1:0]);
      s3_uv_hi_q <= PP_BITS'(s2_uv_q) * PP_BITS'(uv_mag_q[COEF_BITS-1:COEF_HALF]);
      s3_sub_q   <= s2_sub_q;
      // stage 4: full products
      s4_uu_q  <= PROD_BITS'(s3_uu_lo_q) + (PROD_BITS'(s3_uu_hi_q) << COEF_HALF);
      s4_vv_q  <= PROD_BITS'(s3_vv_lo_q) + (PROD_BITS'(s3_vv_hi_q) << COEF_HALF);
      s4_uv_q  <= PROD_BITS'(s3_uv_lo_q) + (PROD_BITS'(s3_uv_hi_q) << COEF_HALF);
      s4_sub_q <= s3_sub_q;
      // stage 5: square terms summed
      s5_p_q   <= PSUM_BITS'(s4_uu_q) + PSUM_BITS'(s4_vv_q);
      s5_m_q   <= s4_uv_q;
      s5_sub_q <= s4_sub_q;
      // stage 6: exponent, clamped at zero
      s6_e_q <= s6_e_d;
      // stage 7
      s7_x_q   <= s7_x_d;
      s7_unf_q <= s7_unf_d;
      // stage 8
      s8_x_q    <= s7_x_q;
      s8_unf_q  <= s7_unf_q;
      s8_nest_q <= s8_nest_d;
      // stage 9
      s9_r0_q  <= s9_r0_d;
      s9_n_q   <= s8_nest_q;
      s9_unf_q <= s8_unf_q;
      // series start
      b_term_q[0] <= b0_r_d;
      b_r_q[0]    <= b0_r_d;
      b_sum_q[0]  <= TSUM_BITS'(1) << Q_FRAC;
      b_n_q[0]    <= b0_n_d;
      b_unf_q[0]  <= s9_unf_q;
      // series steps
      for (int j = 1; j <= TSTEPS; j++) begin
        a_p_q[j]    <= a_p_d[j];
        a_sum_q[j]  <= a_sum_d[j];
        a_r_q[j]    <= b_r_q[j-1];
        a_n_q[j]    <= b_n_q[j-1];
        a_unf_q[j]  <= b_unf_q[j-1];
        b_term_q[j] <= b_term_d[j];
        b_sum_q[j]  <= a_sum_q[j];
        b_r_q[j]    <= a_r_q[j];
        b_n_q[j]    <= a_n_q[j];
        b_unf_q[j]  <= a_unf_q[j];
      end
      // final sum
      f_sum_q <= f_sum_d;
      f_n_q   <= b_n_q[TSTEPS];
      f_unf_q <= b_unf_q[TSTEPS];
    end
  end

  // --------------------------------------------------------------------------
  // Output register with one-word skid
  // --------------------------------------------------------------------------
  logic                pop, fin;
  logic                out_vld_d, skid_vld_d;
  logic [AMP_BITS-1:0] out_amp_d, skid_amp_d;

  always_comb begin
    pop        = out_vld_q && !out_stall_i;
    fin        = adv && f_vld_q;
    out_vld_d  = out_vld_q;
    out_amp_d  = out_amp_q;
    skid_vld_d = skid_vld_q;
    skid_amp_d = skid_amp_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_amp_d  = skid_amp_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d  = fin;
        out_amp_d  = amp_d;
      end
    end else if (fin) begin
      skid_vld_d = 1'b1;
      skid_amp_d = amp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_amp_q  <= out_amp_d;
    skid_amp_q <= skid_amp_d;
  end

  assign out_valid_o = out_vld_q;
  assign amplitude_o = out_amp_q;

`ifndef SYNTHESIS
  // skid word only exists behind a held output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word without output word");

  // skid fills only when the output word was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid filled without output stall");

  // corrected remainder lies below ln 2
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q[0] |-> (b_r_q[0] < LN2_Q32))
    else $error("range reduction remainder out of range");

  // power of two count stays within the non-underflow range
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q[0] && !b_unf_q[0]) |-> (b_n_q[0] <= N_MAX))
    else $error("range reduction count out of range");

  // amplitude never exceeds one
  a_amp_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_amp_q <= (AMP_BITS'(1) << AMP_FRAC_BITS)))
    else $error("amplitude above one");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the Gaussian taper pixel block
// Streams pixel indexes through the block under several register settings
// (reset values, hand-picked extremes, random beams). The expected amplitude
// of every pixel comes from a bit-exact fixed-point predictor kept here, and
// output words are compared in order. Each side idles at random in some settings.
// ============================================================================
module tb;
  import gtp_pkg::*;

  localparam int unsigned IDX_W    = 12;
  localparam int unsigned AMP_FRAC = 16;
  localparam int unsigned AMP_W    = AMP_FRAC + 1;
  localparam int unsigned EXP_FRAC = 36;
  localparam int unsigned EXP_Q    = 32;
  localparam logic [63:0] LN2_FIX  = 64'd2977044472;
  localparam logic [39:0] COEF_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [2:0]  REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  REG_SPARE_LAST  = 3'd7;
  localparam int          STUCK_LIMIT = 2000;
  localparam int          NUM_PHASES  = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [AMP_W-1:0] amp;
  } taper_word_t;

  // Block ports
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [COEF_BITS-1:0]   cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [IDX_W-1:0]       col_index_i = '0;
  logic [IDX_W-1:0]       row_index_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [AMP_W-1:0]       amplitude_o;

  // Register copy used by the predictor
  logic [DIM_BITS-1:0]  cfg_w = 13'd256;
  logic [DIM_BITS-1:0]  cfg_h = 13'd256;
  logic [COEF_BITS-1:0] cfg_uu = '0;
  logic [COEF_BITS-1:0] cfg_uv = '0;
  logic [COEF_BITS-1:0] cfg_vv = '0;

  pixel_t      pixel_q[$];
  taper_word_t amp_pending_q[$];
  pixel_t      next_px;
  taper_word_t pend, got;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  px_taken = 1'b0;
  bit  amp_taken = 1'b0;
  int  stuck_cycles = 0;
  int  mismatch_count = 0;
  int  pixels_taken = 0;
  int  amps_checked = 0;
  int  amps_one = 0;
  int  amps_zero = 0;
  int  amps_frac = 0;
  int  settings_run = 0;

  gaussian_taper_pixel_top #(
    .INDEX_BITS   (IDX_W),
    .AMP_FRAC_BITS(AMP_FRAC)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .col_index_i(col_index_i),
    .row_index_i(row_index_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .amplitude_o(amplitude_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Expected amplitude of one pixel: exact quadratic form, then exp(-E)
  // by range reduction and a 13-term series, all in Q.32
  function automatic logic [AMP_W-1:0] taper_amp(input logic [IDX_W-1:0] col,
                                                  input logic [IDX_W-1:0] row);
    int           u, v;
    logic [12:0]  mu, mv;
    logic         c_neg, uv_neg;
    logic [39:0]  cmag;
    logic [127:0] quad, xterm;
    logic [63:0]  x, n, r, term, sum, s;
    u = int'(col) - int'(cfg_w >> 1);
    v = int'(row) - int'(cfg_h >> 1);
    mu = (u < 0) ? 13'(-u) : 13'(u);
    mv = (v < 0) ? 13'(-v) : 13'(v);
    uv_neg = (u < 0) != (v < 0);
    c_neg = cfg_uv[39];
    cmag = c_neg ? (~cfg_uv + 40'd1) : cfg_uv;
    quad = 128'(mu) * 128'(mu) * 128'(cfg_uu) + 128'(mv) * 128'(mv) * 128'(cfg_vv);
    xterm = 128'(mu) * 128'(mv) * 128'(cmag);
    // indefinite beams can drive the sum negative: clamp to zero
    if (uv_neg != c_neg && mu != 0 && mv != 0 && cmag != 0) begin
      quad = (quad < xterm) ? 128'd0 : quad - xterm;
    end else begin
      quad = quad + xterm;
    end
    if (quad >= (128'd32 << EXP_FRAC)) begin
      return '0;
    end
    x = quad[63:0] >> (EXP_FRAC - EXP_Q);
    n = x / LN2_FIX;
    r = x - n * LN2_FIX;
    term = 64'd1 << EXP_Q;
    sum = 64'd1 << EXP_Q;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * r) >> EXP_Q) / 64'(k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    s = 64'(EXP_Q - AMP_FRAC) + n;
    if (s >= 63) begin
      return '0;
    end
    return AMP_W'((sum + (64'd1 << (s - 1))) >> s);
  endfunction

  // Coefficient that puts exponent 'target' at the image edge
  function automatic logic [39:0] coef_for(input int target, input logic [12:0] dim);
    logic [63:0] half_sq, val;
    half_sq = 64'(dim >> 1) * 64'(dim >> 1);
    if (half_sq == 0) begin
      half_sq = 64'd1;
    end
    val = (64'(target) << EXP_FRAC) / half_sq;
    return (val > 64'(COEF_MAX)) ? COEF_MAX : val[39:0];
  endfunction

  // Cross term as a signed fraction k/16 of uu+vv, kept inside 40 bits
  function automatic logic [39:0] cross_for(input logic [39:0] uu, input logic [39:0] vv,
                                            input int k);
    logic signed [63:0] t;
    t = $signed((64'(uu) + 64'(vv)) >> 4) * k;
    if (t > 64'sh7F_FFFF_FFFF) begin
      t = 64'sh7F_FFFF_FFFF;
    end else if (t < -64'sh80_0000_0000) begin
      t = -64'sh80_0000_0000;
    end
    return t[39:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // One register write per call; the enable stays high across back-to-back calls
  task automatic write_reg(input logic [2:0] idx, input logic [39:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      REG_IMAGE_WIDTH:  cfg_w  = data[12:0];
      REG_IMAGE_HEIGHT: cfg_h  = data[12:0];
      REG_COEF_UU:      cfg_uu = data;
      REG_COEF_UV:      cfg_uv = data;
      REG_COEF_VV:      cfg_vv = data;
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
      write_reg(3'(i), 40'({$urandom, $urandom} & 64'(COEF_MAX)));
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid_i || amp_pending_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic add_pixel(input int col, input int row);
    pixel_q.push_back('{col: IDX_W'(col), row: IDX_W'(row)});
  endtask

  // Mostly pixels inside the image, some near the center, some anywhere
  task automatic queue_random(input int count);
    int span_c, span_r, pick;
    logic [IDX_W-1:0] c, r;
    span_c = (cfg_w == 0 || cfg_w > 4096) ? 4096 : int'(cfg_w);
    span_r = (cfg_h == 0 || cfg_h > 4096) ? 4096 : int'(cfg_h);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        c = IDX_W'($urandom_range(span_c - 1));
        r = IDX_W'($urandom_range(span_r - 1));
      end else if (pick < 85) begin
        c = IDX_W'(int'(cfg_w >> 1) + int'($urandom_range(16)) - 8);
        r = IDX_W'(int'(cfg_h >> 1) + int'($urandom_range(16)) - 8);
      end else begin
        c = IDX_W'($urandom);
        r = IDX_W'($urandom);
      end
      pixel_q.push_back('{col: c, row: r});
    end
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 77; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 77; end
      default:       begin send_idle_pct = 33; stall_pct = 33; end
    endcase
  endtask

  // Pixel driver: new word only once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || px_taken) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_px = pixel_q.pop_front();
          in_valid_i  <= 1'b1;
          col_index_i <= next_px.col;
          row_index_i <= next_px.row;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predict on pixel accept, check on amplitude accept, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      px_taken  = in_valid_i && !in_stall_o;
      amp_taken = out_valid_o && !out_stall_i;
      if (amp_taken) begin
        if (amp_pending_q.size() == 0) begin
          report_mismatch($sformatf("amplitude %0d with no pixel pending", amplitude_o));
        end else begin
          got = amp_pending_q.pop_front();
          amps_checked++;
          if (got.amp == 0) amps_zero++;
          else if (got.amp == AMP_W'(1 << AMP_FRAC)) amps_one++;
          else amps_frac++;
          if (amplitude_o !== got.amp) begin
            report_mismatch($sformatf("pixel (%0d,%0d): amplitude %0d, predicted %0d",
                                      got.col, got.row, amplitude_o, got.amp));
          end
        end
      end
      if (px_taken) begin
        pend.col = col_index_i;
        pend.row = row_index_i;
        pend.amp = taper_amp(col_index_i, row_index_i);
        amp_pending_q.push_back(pend);
        pixels_taken++;
      end
      if (px_taken || amp_taken || cfg_we_i) begin
        stuck_cycles = 0;
      end else if (pixel_q.size() != 0 || in_valid_i || amp_pending_q.size() != 0) begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d amplitudes outstanding",
                 stuck_cycles, amp_pending_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stimulus: reset settings, three hand-picked settings, then random beams
  initial begin
    logic [12:0] w, h;
    logic [39:0] uu, vv;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          // reset values: all coefficients zero, taper is flat
          add_pixel(0, 0);
          add_pixel(4095, 4095);
          add_pixel(128, 128);
          queue_random(10);
        end
        1: begin
          write_reg(REG_IMAGE_WIDTH, {27'h5A5A5A5, 13'd256});
          write_reg(REG_IMAGE_HEIGHT, 40'd200);
          uu = coef_for(12, 13'd256);
          vv = coef_for(10, 13'd200);
          write_reg(REG_COEF_UU, uu);
          write_reg(REG_COEF_UV, cross_for(uu, vv, -4));
          write_reg(REG_COEF_VV, vv);
          finish_writes();
          add_pixel(128, 100);
          add_pixel(129, 101);
          add_pixel(127, 99);
          add_pixel(0, 0);
          add_pixel(4095, 4095);
          add_pixel(4095, 0);
          add_pixel(0, 4095);
          add_pixel(255, 199);
          add_pixel(128, 0);
          add_pixel(int'(12'hAAA), int'(12'h555));
          add_pixel(int'(12'h555), int'(12'hAAA));
          queue_random(40);
        end
        2: begin
          // width masks to zero, height at its 13-bit maximum, coefficients at the limits
          write_reg(REG_IMAGE_WIDTH, 40'hFF_FFFF_E000);
          write_reg(REG_IMAGE_HEIGHT, 40'hA5_5A5A_1FFF);
          write_reg(REG_COEF_UU, COEF_MAX);
          write_reg(REG_COEF_UV, 40'h80_0000_0000);
          write_reg(REG_COEF_VV, COEF_MAX);
          finish_writes();
          add_pixel(0, 4095);
          add_pixel(1, 4095);
          add_pixel(0, 4094);
          add_pixel(4095, 0);
          add_pixel(0, 0);
          queue_random(40);
        end
        3: begin
          // pure cross term at its positive maximum: negative u*v clamps to one
          write_reg(REG_IMAGE_WIDTH, 40'd1);
          write_reg(REG_IMAGE_HEIGHT, 40'd4096);
          write_reg(REG_COEF_UU, 40'd0);
          write_reg(REG_COEF_UV, 40'h7F_FFFF_FFFF);
          write_reg(REG_COEF_VV, 40'd0);
          finish_writes();
          add_pixel(0, 0);
          add_pixel(0, 2048);
          add_pixel(1, 2049);
          add_pixel(2, 2049);
          add_pixel(1, 2051);
          add_pixel(4095, 2047);
          add_pixel(4095, 4095);
          queue_random(40);
        end
        default: begin
          w = 13'($urandom_range(1, 4096));
          h = 13'($urandom_range(1, 4096));
          if ($urandom_range(3) == 0) w = 13'($urandom_range(1, 32));
          if ($urandom_range(3) == 0) h = 13'($urandom_range(1, 32));
          uu = ($urandom_range(7) == 0) ? 40'd0 : coef_for($urandom_range(1, 48), w);
          vv = ($urandom_range(7) == 0) ? 40'd0 : coef_for($urandom_range(1, 48), h);
          write_reg(REG_IMAGE_WIDTH, {27'($urandom), w});
          write_reg(REG_IMAGE_HEIGHT, {27'($urandom), h});
          write_reg(REG_COEF_UU, uu);
          write_reg(REG_COEF_UV, cross_for(uu, vv, int'($urandom_range(40)) - 20));
          write_reg(REG_COEF_VV, vv);
          finish_writes();
          queue_random(85);
        end
      endcase
      set_idling(idle_mode_e'(phase % 4));
      settings_run++;
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (amp_pending_q.size() != 0) begin
      report_mismatch($sformatf("%0d amplitudes never arrived", amp_pending_q.size()));
    end
    $display("Ran %0d pixels through %0d register settings, %0d amplitude words checked",
             pixels_taken, settings_run, amps_checked);
    $display("Amplitudes seen: %0d exactly one, %0d underflowed to zero, %0d in between",
             amps_one, amps_zero, amps_frac);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
